// ===== src/iit_pkg.sv =====
// Shared types and the 1-D butterfly of the 4x4 inverse integer transform.
package iit_pkg;

	localparam int unsigned CoefW  = 16;
	localparam int unsigned VertW  = 18;
	localparam int unsigned WideW  = 20;
	localparam int unsigned ResW   = 14;
	localparam int unsigned RndAdd = 32;
	localparam int unsigned RndSh  = 6;

	typedef logic signed [CoefW-1:0] coef_t;
	typedef logic signed [VertW-1:0] vert_t;
	typedef logic signed [WideW-1:0] wide_t;
	typedef logic signed [ResW-1:0]  res_t;

	typedef struct packed {
		wide_t y3;
		wide_t y2;
		wide_t y1;
		wide_t y0;
	} bfly_t;

	// Even/odd butterfly; the odd terms are half-weighted with a floor shift.
	function automatic bfly_t butterfly(wide_t x0, wide_t x1, wide_t x2, wide_t x3);
		wide_t es;
		wide_t ed;
		wide_t od;
		wide_t os;
		bfly_t y;
		es   = x0 + x2;
		ed   = x0 - x2;
		od   = (x1 >>> 1) - x3;
		os   = x1 + (x3 >>> 1);
		y.y0 = es + os;
		y.y1 = ed + od;
		y.y2 = ed - od;
		y.y3 = es - os;
		return y;
	endfunction

endpackage

// ===== src/iit_col_lane.sv =====
// One column lane: the vertical butterfly over the four stored rows of a column.
module iit_col_lane (
	input  iit_pkg::coef_t c0,
	input  iit_pkg::coef_t c1,
	input  iit_pkg::coef_t c2,
	input  iit_pkg::coef_t c3,
	output iit_pkg::vert_t v0,
	output iit_pkg::vert_t v1,
	output iit_pkg::vert_t v2,
	output iit_pkg::vert_t v3
);

	iit_pkg::bfly_t y;

	always_comb begin
		y = iit_pkg::butterfly(iit_pkg::wide_t'(c0), iit_pkg::wide_t'(c1),
			iit_pkg::wide_t'(c2), iit_pkg::wide_t'(c3));
	end

	// Column results need 18 bits; the upper bits are sign copies.
	assign v0 = y.y0[iit_pkg::VertW-1:0];
	assign v1 = y.y1[iit_pkg::VertW-1:0];
	assign v2 = y.y2[iit_pkg::VertW-1:0];
	assign v3 = y.y3[iit_pkg::VertW-1:0];

endmodule

// ===== src/iit_row_merge.sv =====
// Merging stage: horizontal butterfly across the lane results of one row, then rounding.
module iit_row_merge (
	input  iit_pkg::vert_t t0,
	input  iit_pkg::vert_t t1,
	input  iit_pkg::vert_t t2,
	input  iit_pkg::vert_t t3,
	output iit_pkg::res_t  r0,
	output iit_pkg::res_t  r1,
	output iit_pkg::res_t  r2,
	output iit_pkg::res_t  r3
);

	iit_pkg::bfly_t y;
	logic signed [iit_pkg::WideW:0] s0;
	logic signed [iit_pkg::WideW:0] s1;
	logic signed [iit_pkg::WideW:0] s2;
	logic signed [iit_pkg::WideW:0] s3;

	always_comb begin
		y = iit_pkg::butterfly(iit_pkg::wide_t'(t0), iit_pkg::wide_t'(t1),
			iit_pkg::wide_t'(t2), iit_pkg::wide_t'(t3));
		s0 = (iit_pkg::WideW+1)'(y.y0) + (iit_pkg::WideW+1)'(iit_pkg::RndAdd);
		s1 = (iit_pkg::WideW+1)'(y.y1) + (iit_pkg::WideW+1)'(iit_pkg::RndAdd);
		s2 = (iit_pkg::WideW+1)'(y.y2) + (iit_pkg::WideW+1)'(iit_pkg::RndAdd);
		s3 = (iit_pkg::WideW+1)'(y.y3) + (iit_pkg::WideW+1)'(iit_pkg::RndAdd);
	end

	// Dropping the low bits is a floor shift; the result always fits 14 bits.
	assign r0 = s0[iit_pkg::RndSh +: iit_pkg::ResW];
	assign r1 = s1[iit_pkg::RndSh +: iit_pkg::ResW];
	assign r2 = s2[iit_pkg::RndSh +: iit_pkg::ResW];
	assign r3 = s3[iit_pkg::RndSh +: iit_pkg::ResW];

endmodule

// ===== src/inverse_integer_transform_4x4.sv =====
// Top level of the 4x4 inverse integer transform with row-wise stream ports.
// The first result row passes through the transpose buffer and the output register
// after the edge that accepts the fourth input row; the other three rows follow one
// per cycle while m_axis_tready stays high. Throughput: one input and one result item
// per cycle unless stalled, set by the one horizontal merge unit producing one row per cycle.
// Reset (arst_n low, asynchronous) empties the row counter and all valid flags.
module inverse_integer_transform_4x4 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // coef_a, coef_b, coef_c, coef_d (16 bits each)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // residual_a, residual_b, residual_c, residual_d (14 each)
	output logic        m_axis_tlast   // final_row
);

	// The input store collects the four rows of one block. Once full, the four
	// column lanes run the vertical pass combinationally and, once the transpose
	// buffer is free, park the result there, freeing the store for the next block at once.
	iit_pkg::coef_t store_q [4][4];
	logic [1:0]     rows_q;
	logic           full_q;

	iit_pkg::vert_t lane_v [4][4];   // [row][column] from the lanes
	iit_pkg::vert_t tmp_q  [4][4];
	logic           tmp_valid_q;
	logic [1:0]     out_row_q;

	iit_pkg::res_t  res [4];
	iit_pkg::res_t  res_q [4];
	logic           out_valid_q;
	logic           last_q;

	logic in_acc;
	logic step;
	logic xfer;

	// The merge unit fires whenever a parked block remains and the output
	// register is empty or being emptied.
	assign step = tmp_valid_q && (!out_valid_q || m_axis_tready);
	// The full store moves into the transpose buffer when that buffer is free
	// or hands its last row to the output this cycle.
	assign xfer = full_q && (!tmp_valid_q || (step && out_row_q == 2'd3));

	// A new row may arrive in the same cycle as the transfer, since the lanes
	// read the store before the edge that overwrites row zero.
	assign s_axis_tready = !full_q || xfer;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	for (genvar x = 0; x < 4; x++) begin : g_lane
		iit_col_lane u_lane (
			.c0 (store_q[0][x]),
			.c1 (store_q[1][x]),
			.c2 (store_q[2][x]),
			.c3 (store_q[3][x]),
			.v0 (lane_v[0][x]),
			.v1 (lane_v[1][x]),
			.v2 (lane_v[2][x]),
			.v3 (lane_v[3][x])
		);
	end

	iit_row_merge u_merge (
		.t0 (tmp_q[out_row_q][0]),
		.t1 (tmp_q[out_row_q][1]),
		.t2 (tmp_q[out_row_q][2]),
		.t3 (tmp_q[out_row_q][3]),
		.r0 (res[0]),
		.r1 (res[1]),
		.r2 (res[2]),
		.r3 (res[3])
	);

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			store_q[rows_q][0] <= s_axis_tdata[15:0];
			store_q[rows_q][1] <= s_axis_tdata[31:16];
			store_q[rows_q][2] <= s_axis_tdata[47:32];
			store_q[rows_q][3] <= s_axis_tdata[63:48];
		end
		if (xfer) begin
			tmp_q <= lane_v;
		end
		if (step) begin
			res_q  <= res;
			last_q <= (out_row_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= 2'd0;
			full_q      <= 1'b0;
			tmp_valid_q <= 1'b0;
			out_row_q   <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				rows_q <= rows_q + 2'd1;
			end
			if (in_acc && rows_q == 2'd3) begin
				full_q <= 1'b1;
			end else if (xfer) begin
				full_q <= 1'b0;
			end
			if (xfer) begin
				tmp_valid_q <= 1'b1;
			end else if (step && out_row_q == 2'd3) begin
				tmp_valid_q <= 1'b0;
			end
			if (step) begin
				out_row_q   <= out_row_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q[3], res_q[2], res_q[1], res_q[0]};
	assign m_axis_tlast  = last_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the 4x4 inverse integer transform with row-wise stream ports.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The limit is set far beyond the slowest correct run: about 350 rows with
	// 70 percent idling on one side plus one long receiver stall.
	localparam int unsigned CycleLimit   = 100000;
	// The first result row follows the fourth row through the transpose buffer and output register.
	// This many quiet cycles at the end catch any stray extra row.
	localparam int unsigned DrainCycles  = 20;
	localparam int unsigned StallCycles  = 150;
	localparam int unsigned PhaseBlocks0 = 30;
	localparam int unsigned PressBlocks  = 4;
	localparam int unsigned PhaseBlocks1 = 29;
	localparam int unsigned PhaseBlocks2 = 19;

	// One expected residual row: four samples and the last-row mark.
	typedef struct {
		iit_pkg::res_t sample [4];
		logic          final_row;
	} residual_row_t;

	// Scoreboard: it collects coefficient rows into a 4x4 block, runs its own
	// copy of the transform once the fourth row is in, and queues the four
	// residual rows that the block must produce.
	class residual_scoreboard;
		iit_pkg::coef_t coef_block [16];
		bit [1:0]       rows_in      = 2'd0;
		residual_row_t  expected_rows [$];
		int unsigned    mismatches   = 0;
		int unsigned    rows_taken   = 0;
		int unsigned    rows_checked = 0;

		// 1-D even/odd butterfly; odd terms are halved with a floor shift.
		function void butterfly_1d(input int x0, input int x1, input int x2,
				input int x3, output int y [4]);
			int es;
			int ed;
			int od;
			int os;
			es   = x0 + x2;
			ed   = x0 - x2;
			od   = (x1 >>> 1) - x3;
			os   = x1 + (x3 >>> 1);
			y[0] = es + os;
			y[1] = ed + od;
			y[2] = ed - od;
			y[3] = es - os;
		endfunction

		function void note_coef_row(input logic [63:0] d);
			int            vert [4][4];
			int            y [4];
			int            v;
			residual_row_t res_row;
			for (int c = 0; c < 4; c++) begin
				coef_block[4 * rows_in + c] =
						iit_pkg::coef_t'(d[iit_pkg::CoefW * c +: iit_pkg::CoefW]);
			end
			rows_taken++;
			if (rows_in != 2'd3) begin
				rows_in++;
				return;
			end
			rows_in = 2'd0;
			// Vertical pass over each column.
			for (int x = 0; x < 4; x++) begin
				butterfly_1d(coef_block[x], coef_block[4 + x], coef_block[8 + x],
						coef_block[12 + x], y);
				for (int r = 0; r < 4; r++) begin
					vert[r][x] = y[r];
				end
			end
			// Horizontal pass over each row, then round by 32 and shift by 6.
			for (int r = 0; r < 4; r++) begin
				butterfly_1d(vert[r][0], vert[r][1], vert[r][2], vert[r][3], y);
				for (int x = 0; x < 4; x++) begin
					v = (y[x] + int'(iit_pkg::RndAdd)) >>> iit_pkg::RndSh;
					res_row.sample[x] = iit_pkg::res_t'(v);
				end
				res_row.final_row = (r == 3);
				expected_rows.push_back(res_row);
			end
		endfunction

		function void check_residual_row(input logic [55:0] d, input logic last);
			residual_row_t exp_row;
			iit_pkg::res_t got;
			if (expected_rows.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected residual row, actual data %h last %b",
						$time, d, last);
				return;
			end
			exp_row = expected_rows.pop_front();
			for (int x = 0; x < 4; x++) begin
				got = d[iit_pkg::ResW * x +: iit_pkg::ResW];
				if (got !== exp_row.sample[x]) begin
					mismatches++;
					$display("%0t: mismatch in residual column %0d, expected %0d actual %0d",
							$time, x, exp_row.sample[x], got);
				end
			end
			if (last !== exp_row.final_row) begin
				mismatches++;
				$display("%0t: mismatch in final_row, expected %b actual %b",
						$time, exp_row.final_row, last);
			end
			rows_checked++;
		endfunction
	endclass

	bit          clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;  // coef_a, coef_b, coef_c, coef_d (16 bits each)
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;         // residual_a, residual_b, residual_c, residual_d (14 each)
	logic        m_axis_tlast;         // final_row

	residual_scoreboard sb = new;

	int unsigned send_idle_pct = 31;
	int unsigned recv_idle_pct = 70;
	bit          stall_request = 1'b0;
	int unsigned stall_left    = 0;
	int unsigned cycle_count   = 0;

	inverse_integer_transform_4x4 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 20 ns clock period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random back-pressure, or a long hold-off when the stimulus asks
	// for one. The hold-off is counted here so the sender keeps offering items
	// meanwhile and the block has to stall its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_request) begin
			stall_request = 1'b0;
			stall_left    = StallCycles;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: handshakes are sampled at the rising edge, before any of the
	// nonblocking updates of that edge take effect.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_residual_row(m_axis_tdata, m_axis_tlast);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_coef_row(s_axis_tdata);
			end
		end
	end

	function automatic logic [63:0] pack_row(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d);
		return {d, c, b, a};
	endfunction

	// Coefficient source for random blocks: full range, small values near the
	// rounding thresholds, the extremes, or a mostly empty block.
	function automatic logic [15:0] pick_coef(input int unsigned mode);
		logic [15:0] v;
		case (mode)
			0: begin
				v = 16'($urandom);
			end
			1: begin
				v = 16'($signed($urandom_range(160)) - 80);
			end
			2: begin
				case ($urandom_range(4))
					0:       v = 16'h7FFF;
					1:       v = 16'h8000;
					2:       v = 16'h0000;
					3:       v = 16'hFFFF;
					default: v = 16'h0001;
				endcase
			end
			default: begin
				v = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000;
			end
		endcase
		return v;
	endfunction

	// Offer one coefficient row, after an optional random gap, and hold it
	// until it is accepted. Returns in the step of the accepting edge, so
	// tvalid stays high without a dip when the next row follows directly.
	task automatic send_coef_row(input logic [63:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_random_blocks(input int unsigned count);
		int unsigned mode;
		for (int unsigned n = 0; n < count; n++) begin
			mode = $urandom_range(4);
			for (int r = 0; r < 4; r++) begin
				send_coef_row(pack_row(pick_coef(mode), pick_coef(mode),
						pick_coef(mode), pick_coef(mode)));
			end
		end
	endtask

	task automatic wait_for_results();
		while (sb.expected_rows.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed blocks: all zero, all maximum, all minimum, a checkerboard
		// of both extremes (largest magnitudes after both passes), small values
		// straddling the rounding step, and negative odd terms that exercise
		// the floor halving.
		repeat (4) send_coef_row(pack_row(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		repeat (4) send_coef_row(pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		repeat (4) send_coef_row(pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000));
		for (int r = 0; r < 4; r++) begin
			if (r % 2 == 1) begin
				send_coef_row(pack_row(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
			end else begin
				send_coef_row(pack_row(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
			end
		end
		send_coef_row(pack_row(-16'sd1, 16'sd1, -16'sd2, 16'sd2));
		send_coef_row(pack_row(16'sd31, -16'sd32, 16'sd33, -16'sd33));
		send_coef_row(pack_row(16'sd0, -16'sd31, 16'sd0, 16'sd32));
		send_coef_row(pack_row(-16'sd64, 16'sd64, -16'sd65, 16'sd65));
		send_coef_row(pack_row(16'sd0, -16'sd1, 16'sd0, -16'sd3));
		send_coef_row(pack_row(-16'sd1, -16'sd3, -16'sd5, -16'sd7));
		send_coef_row(pack_row(16'h7FFF, -16'sd1, 16'h8000, 16'sd1));
		send_coef_row(pack_row(16'h0000, 16'h8000, 16'h0000, 16'h7FFF));

		// Phase one: sender idles lightly, receiver heavily.
		send_random_blocks(PhaseBlocks0);

		// Long receiver hold-off while the sender keeps offering rows, then a
		// sender pause until every expected row has drained.
		stall_request = 1'b1;
		send_random_blocks(PressBlocks);
		s_axis_tvalid <= 1'b0;
		wait_for_results();

		// Phase two: the idling is swapped between the two sides.
		send_idle_pct = 70;
		recv_idle_pct = 31;
		send_random_blocks(PhaseBlocks1);

		// Phase three: back-to-back rows on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_blocks(PhaseBlocks2);
		s_axis_tvalid <= 1'b0;

		wait_for_results();
		repeat (DrainCycles) @(posedge clk);

		$display("summary: %0d coefficient rows in %0d blocks sent, %0d residual rows checked,",
				sb.rows_taken, sb.rows_taken / 4, sb.rows_checked);
		$display("summary: extremes, rounding edges, long output stall and three idling mixes.");
		if (sb.mismatches == 0 && sb.expected_rows.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
